// ----- design/dlps_pkg.sv -----
// shared types and constants of the dijet leading-pair selector
package dlps_pkg;

    // field widths
    localparam int unsigned MOM_W   = 20;
    localparam int unsigned ENE_W   = 19;
    localparam int unsigned PT2_W   = 40;
    localparam int unsigned PZ2_W   = 39;
    localparam int unsigned FAC_W   = 16;
    localparam int unsigned MASS_W  = 42;
    localparam int unsigned M2_W    = 43;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned OPD_W   = 21;
    localparam int unsigned PROD_W  = 2 * OPD_W;
    localparam int unsigned ACC_W   = 57;
    localparam int unsigned HALF_W  = 20;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ETA_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PT_MIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS_MAX   = 2'd2;

    // reset values of the configuration registers
    localparam logic [FAC_W-1:0]  ETA_FACTOR_RST = 16'd9371;
    localparam logic [PT2_W-1:0]  PT_MIN_RST     = 40'd25600;
    localparam logic [MASS_W-1:0] MASS_MAX_RST   = 42'd16000000;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    // one jet four-vector
    typedef struct packed {
        logic signed [MOM_W-1:0] px;
        logic signed [MOM_W-1:0] py;
        logic signed [MOM_W-1:0] pz;
        logic        [ENE_W-1:0] energy;
    } jet_t;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic en;       // update the accumulator
        logic clear;    // start from zero instead of the accumulator
        logic sub;      // subtract the product instead of adding it
        logic shift;    // weight the product by 2^HALF_W
    } mac_op_t;

    // control of the leading-pair store
    typedef struct packed {
        logic take;     // a jet has finished its cut evaluation
        logic eta_pass; // that jet passed the eta cut
        logic clear;    // event reported, drop all event state
    } store_upd_t;

endpackage

// ----- design/dlps_mac.sv -----
// shared signed multiply-accumulate unit
module dlps_mac (
    input  logic                                  clk,
    input  logic signed [dlps_pkg::OPD_W-1:0]     op_a,
    input  logic signed [dlps_pkg::OPD_W-1:0]     op_b,
    input  dlps_pkg::mac_op_t                     op,
    output logic signed [dlps_pkg::ACC_W-1:0]     acc
);
    import dlps_pkg::*;

    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    // product, optionally weighted by the upper half position
    always_comb
    begin
        prod = PROD_W'(op_a) * PROD_W'(op_b);
        term = ACC_W'(prod);
        if (op.shift)
        begin
            term = term <<< HALF_W;
        end
        base = op.clear ? '0 : acc_reg;
        acc_next = op.sub ? (base - term) : (base + term);
    end

    // accumulator
    always_ff @(posedge clk)
    begin
        if (op.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ----- design/dlps_pair_store.sv -----
// per-event counts and the two highest-pt selected jets
module dlps_pair_store (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dlps_pkg::jet_t                   jet,
    input  logic [dlps_pkg::PT2_W-1:0]       jet_pt2,
    input  logic [dlps_pkg::PT2_W-1:0]       pt_min,
    input  dlps_pkg::store_upd_t             upd,
    output dlps_pkg::jet_t                   lead,
    output dlps_pkg::jet_t                   second,
    output logic [dlps_pkg::PT2_W-1:0]       lead_pt2,
    output logic [dlps_pkg::PT2_W-1:0]       second_pt2,
    output logic [dlps_pkg::CNT_W-1:0]       sel_count,
    output logic [dlps_pkg::CNT_W-1:0]       eta_count
);
    import dlps_pkg::*;

    jet_t             lead_reg, lead_next;
    jet_t             second_reg, second_next;
    logic [PT2_W-1:0] lead_pt2_reg, lead_pt2_next;
    logic [PT2_W-1:0] second_pt2_reg, second_pt2_next;
    logic [CNT_W-1:0] sel_cnt_reg, sel_cnt_next;
    logic [CNT_W-1:0] eta_cnt_reg, eta_cnt_next;
    logic             selected;

    // cut decision and ranking against the kept jets
    always_comb
    begin
        lead_next       = lead_reg;
        second_next     = second_reg;
        lead_pt2_next   = lead_pt2_reg;
        second_pt2_next = second_pt2_reg;
        sel_cnt_next    = sel_cnt_reg;
        eta_cnt_next    = eta_cnt_reg;
        selected        = upd.take && upd.eta_pass && (jet_pt2 > pt_min);
        if (upd.clear)
        begin
            lead_next       = '0;
            second_next     = '0;
            lead_pt2_next   = '0;
            second_pt2_next = '0;
            sel_cnt_next    = '0;
            eta_cnt_next    = '0;
        end
        else
        begin
            if (upd.take && upd.eta_pass && eta_cnt_reg != CNT_MAX)
            begin
                eta_cnt_next = eta_cnt_reg + 1'b1;
            end
            if (selected && sel_cnt_reg != CNT_MAX)
            begin
                sel_cnt_next = sel_cnt_reg + 1'b1;
            end
            // strictly greater: the earlier jet keeps its place on a tie
            if (selected && jet_pt2 > lead_pt2_reg)
            begin
                second_next     = lead_reg;
                second_pt2_next = lead_pt2_reg;
                lead_next       = jet;
                lead_pt2_next   = jet_pt2;
            end
            else if (selected && jet_pt2 > second_pt2_reg)
            begin
                second_next     = jet;
                second_pt2_next = jet_pt2;
            end
        end
    end

    // event state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg       <= '0;
            second_reg     <= '0;
            lead_pt2_reg   <= '0;
            second_pt2_reg <= '0;
            sel_cnt_reg    <= '0;
            eta_cnt_reg    <= '0;
        end
        else
        begin
            lead_reg       <= lead_next;
            second_reg     <= second_next;
            lead_pt2_reg   <= lead_pt2_next;
            second_pt2_reg <= second_pt2_next;
            sel_cnt_reg    <= sel_cnt_next;
            eta_cnt_reg    <= eta_cnt_next;
        end
    end

    assign lead       = lead_reg;
    assign second     = second_reg;
    assign lead_pt2   = lead_pt2_reg;
    assign second_pt2 = second_pt2_reg;
    assign sel_count  = sel_cnt_reg;
    assign eta_count  = eta_cnt_reg;

endmodule

// ----- design/dijet_leading_pair_selector.sv -----
// top level: sequencer, operand selection, configuration and result register
//
// Jets of one event arrive one word at a time; a word with tlast ends the event and
// produces one result word. All products (px^2, py^2, pz^2, the eta factor times pt^2
// in two halves, and the four terms of the pair mass) go through a single 21x21
// signed multiply-accumulate unit, one product per cycle, and the block takes no new
// word while it works. A jet word steps through PX, PY, PZ, FLO, FHI and DEC; a word with
// tlast then (or straight away, without a jet) steps through SX, SY, SZ, SE for the pair
// mass and OUT for the result load; a word with neither a jet nor tlast leaves it idle. Jets
// beyond MAX_JETS in one event are ignored. The result waits in an output register,
// so new jets are taken while it is pending; only the next result load waits for it.
module dijet_leading_pair_selector #(
    parameter int unsigned MAX_JETS = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // slave side: jet words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [79:0]                         s_tdata,  // jet_px, jet_py, jet_pz, jet_energy
    input  logic                                s_tuser,  // jet_present
    input  logic                                s_tlast,  // event_last
    // master side: event result words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // selected_count, eta_pass_count, pair_found, pair_mass_squared, mass_pass,
    // lead_pt_squared, second_pt_squared
    output logic [143:0]                        m_tdata,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dlps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dlps_pkg::MASS_W-1:0]         cfg_data
);
    import dlps_pkg::*;

    localparam int unsigned JW = $clog2(MAX_JETS + 1);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_PX    = 12'b0000_0000_0010,
        ST_PY    = 12'b0000_0000_0100,
        ST_PZ    = 12'b0000_0000_1000,
        ST_FLO   = 12'b0000_0001_0000,
        ST_FHI   = 12'b0000_0010_0000,
        ST_DEC   = 12'b0000_0100_0000,
        ST_SX    = 12'b0000_1000_0000,
        ST_SY    = 12'b0001_0000_0000,
        ST_SZ    = 12'b0010_0000_0000,
        ST_SE    = 12'b0100_0000_0000,
        ST_OUT   = 12'b1000_0000_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic [JW-1:0]            jets_seen_reg, jets_seen_next;

    // configuration
    logic [FAC_W-1:0]         eta_factor_reg;
    logic [PT2_W-1:0]         pt_min_reg;
    logic [MASS_W-1:0]        mass_max_reg;

    // captured word and intermediate squares
    jet_t                     jet_reg;
    logic                     last_reg;
    logic [PT2_W-1:0]         pt2_reg;
    logic [PZ2_W-1:0]         pz2_reg;

    // result register
    logic                     out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]         out_sel_reg;
    logic [CNT_W-1:0]         out_eta_reg;
    logic                     out_pair_reg;
    logic signed [M2_W-1:0]   out_m2_reg;
    logic                     out_pass_reg;
    logic [PT2_W-1:0]         out_lead_pt2_reg;
    logic [PT2_W-1:0]         out_second_pt2_reg;

    // datapath nets
    logic                     in_accept;
    logic                     jet_room;
    logic                     out_load;
    logic                     eta_pass;
    logic                     pair;
    logic                     mass_pass;
    logic signed [OPD_W-1:0]  op_a, op_b;
    mac_op_t                  mac_op;
    logic signed [ACC_W-1:0]  acc;
    store_upd_t               upd;
    jet_t                     lead, second;
    logic [PT2_W-1:0]         lead_pt2, second_pt2;
    logic [CNT_W-1:0]         sel_count, eta_count;
    logic signed [OPD_W-1:0]  sum_x, sum_y, sum_z, sum_e;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign jet_room  = (jets_seen_reg < JW'(MAX_JETS));
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);
    assign cfg_ready = 1'b1;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser && jet_room)
                    begin
                        state_next = ST_PX;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_SX;
                    end
                end
            end
            ST_PX:  state_next = ST_PY;
            ST_PY:  state_next = ST_PZ;
            ST_PZ:  state_next = ST_FLO;
            ST_FLO: state_next = ST_FHI;
            ST_FHI: state_next = ST_DEC;
            ST_DEC: state_next = last_reg ? ST_SX : ST_IDLE;
            ST_SX:  state_next = ST_SY;
            ST_SY:  state_next = ST_SZ;
            ST_SZ:  state_next = ST_SE;
            ST_SE:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // jets counted in the current event
    always_comb
    begin
        jets_seen_next = jets_seen_reg;
        if (out_load)
        begin
            jets_seen_next = '0;
        end
        else if (in_accept && s_tuser && jet_room)
        begin
            jets_seen_next = jets_seen_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            jets_seen_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            jets_seen_reg <= jets_seen_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_factor_reg <= ETA_FACTOR_RST;
            pt_min_reg     <= PT_MIN_RST;
            mass_max_reg   <= MASS_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ETA_FACTOR: eta_factor_reg <= cfg_data[FAC_W-1:0];
                CFG_PT_MIN:     pt_min_reg     <= cfg_data[PT2_W-1:0];
                CFG_MASS_MAX:   mass_max_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // captured word and saved squares
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            jet_reg.px     <= s_tdata[19:0];
            jet_reg.py     <= s_tdata[39:20];
            jet_reg.pz     <= s_tdata[59:40];
            jet_reg.energy <= s_tdata[78:60];
            last_reg       <= s_tlast;
        end
        if (state_reg == ST_PZ)
        begin
            pt2_reg <= acc[PT2_W-1:0];
        end
        if (state_reg == ST_FLO)
        begin
            pz2_reg <= acc[PZ2_W-1:0];
        end
    end

    // component sums of the leading pair
    assign sum_x = {lead.px[MOM_W-1], lead.px} + {second.px[MOM_W-1], second.px};
    assign sum_y = {lead.py[MOM_W-1], lead.py} + {second.py[MOM_W-1], second.py};
    assign sum_z = {lead.pz[MOM_W-1], lead.pz} + {second.pz[MOM_W-1], second.pz};
    assign sum_e = {2'b00, lead.energy} + {2'b00, second.energy};

    // operand selection and accumulator control per step
    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        mac_op = '{en: 1'b0, clear: 1'b0, sub: 1'b0, shift: 1'b0};
        unique case (state_reg)
            ST_PX:
            begin
                op_a   = {jet_reg.px[MOM_W-1], jet_reg.px};
                op_b   = op_a;
                mac_op = '{en: 1'b1, clear: 1'b1, sub: 1'b0, shift: 1'b0};
            end
            ST_PY:
            begin
                op_a   = {jet_reg.py[MOM_W-1], jet_reg.py};
                op_b   = op_a;
                mac_op = '{en: 1'b1, clear: 1'b0, sub: 1'b0, shift: 1'b0};
            end
            ST_PZ:
            begin
                op_a   = {jet_reg.pz[MOM_W-1], jet_reg.pz};
                op_b   = op_a;
                mac_op = '{en: 1'b1, clear: 1'b1, sub: 1'b0, shift: 1'b0};
            end
            ST_FLO:
            begin
                op_a   = {5'b0, eta_factor_reg};
                op_b   = {1'b0, pt2_reg[HALF_W-1:0]};
                mac_op = '{en: 1'b1, clear: 1'b1, sub: 1'b0, shift: 1'b0};
            end
            ST_FHI:
            begin
                op_a   = {5'b0, eta_factor_reg};
                op_b   = {1'b0, pt2_reg[PT2_W-1:HALF_W]};
                mac_op = '{en: 1'b1, clear: 1'b0, sub: 1'b0, shift: 1'b1};
            end
            ST_SX:
            begin
                op_a   = sum_x;
                op_b   = sum_x;
                mac_op = '{en: 1'b1, clear: 1'b1, sub: 1'b1, shift: 1'b0};
            end
            ST_SY:
            begin
                op_a   = sum_y;
                op_b   = sum_y;
                mac_op = '{en: 1'b1, clear: 1'b0, sub: 1'b1, shift: 1'b0};
            end
            ST_SZ:
            begin
                op_a   = sum_z;
                op_b   = sum_z;
                mac_op = '{en: 1'b1, clear: 1'b0, sub: 1'b1, shift: 1'b0};
            end
            ST_SE:
            begin
                op_a   = sum_e;
                op_b   = sum_e;
                mac_op = '{en: 1'b1, clear: 1'b0, sub: 1'b0, shift: 1'b0};
            end
            default: ;
        endcase
    end

    dlps_mac u_mac (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .op   (mac_op),
        .acc  (acc)
    );

    // eta cut: 256*pz^2 < factor*pt^2
    assign eta_pass = ({{(ACC_W - PZ2_W - 9){1'b0}}, pz2_reg, 8'b0} < acc[ACC_W-2:0]);

    assign upd = '{take: (state_reg == ST_DEC), eta_pass: eta_pass, clear: out_load};

    dlps_pair_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .jet        (jet_reg),
        .jet_pt2    (pt2_reg),
        .pt_min     (pt_min_reg),
        .upd        (upd),
        .lead       (lead),
        .second     (second),
        .lead_pt2   (lead_pt2),
        .second_pt2 (second_pt2),
        .sel_count  (sel_count),
        .eta_count  (eta_count)
    );

    // pair mass cut, a negative mass squared passes
    assign pair      = (sel_count >= CNT_W'(2));
    assign mass_pass = pair && (acc < $signed({{(ACC_W - MASS_W){1'b0}}, mass_max_reg}));

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sel_reg        <= sel_count;
            out_eta_reg        <= eta_count;
            out_pair_reg       <= pair;
            out_m2_reg         <= pair ? acc[M2_W-1:0] : '0;
            out_pass_reg       <= mass_pass;
            out_lead_pt2_reg   <= lead_pt2;
            out_second_pt2_reg <= second_pt2;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_second_pt2_reg, out_lead_pt2_reg, out_pass_reg,
                       out_m2_reg, out_pair_reg, out_eta_reg, out_sel_reg};

`ifndef SYNTHESIS
    // a passing mass needs a pair
    a_pass_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_pass_reg || out_pair_reg))
        else $error("mass pass reported without a pair");

    // no pair reports a zero mass and an empty second slot
    a_no_pair_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_pair_reg) |-> (out_m2_reg == '0 && out_second_pt2_reg == '0))
        else $error("mass or second pt set without a pair");

    // selected jets are a subset of eta-passing jets
    a_sel_le_eta: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_sel_reg <= out_eta_reg))
        else $error("selected count above eta count");

    // a report clears the event state
    a_event_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (sel_count == '0 && eta_count == '0 && jets_seen_reg == '0))
        else $error("event state not cleared after report");
`endif

endmodule
